// File: rtl/bre_pkg.sv
`default_nettype none
package bre_pkg;

  // A literal segment splits into runs once three equal bytes line up.
  localparam int MIN_RUN = 3;
  localparam int CHUNK_BYTES = 8;

  // One packet for the back end to emit.
  typedef struct packed {
    logic       is_run;
    logic [7:0] len;
    logic [7:0] value;
    logic       bank;
    logic       step_last;
    logic       row_done;
  } cmd_t;

  // Up to two packets leave the front end per transfer, oldest in c0.
  typedef struct packed {
    logic [1:0] n;
    cmd_t       c0;
    cmd_t       c1;
  } push_t;

  // Back end reports that a literal bank has been fully read out.
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_clr_t;

  typedef enum logic {
    BK_IDLE,
    BK_LIT
  } bk_state_t;

endpackage
`default_nettype wire

// File: rtl/bre_ram.sv
`default_nettype none
module bre_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 34,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: rtl/bre_cmd_fifo.sv
`default_nettype none
module bre_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire bre_pkg::push_t push,
  input  wire logic          pop,
  output bre_pkg::cmd_t      head,
  output logic               empty,
  output logic               room2
);

  localparam int DEPTH = 4;
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  bre_pkg::cmd_t  mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [PW-1:0]  wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr_r + PW'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push.n);
    rd_ptr_nxt = pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(push.n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.c0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.c1;
    end
  end

  assign head  = mem_r[rd_ptr_r];
  assign empty = (cnt_r == '0);
  assign room2 = (cnt_r <= CW'(DEPTH - 2));

endmodule
`default_nettype wire

// File: rtl/bre_front.sv
`default_nettype none
module bre_front #(
  parameter int MAX_LITERAL = 128,
  parameter int MAX_RUN_LEN = 128,
  localparam int WORDS = MAX_LITERAL / 8 + 1,
  localparam int WW = (WORDS > 1) ? $clog2(WORDS) : 1,
  localparam int AW = $clog2(2 * WORDS)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_row_last,
  input  wire logic              room2,
  output bre_pkg::push_t         push,
  input  wire bre_pkg::bank_clr_t clr,
  output logic                   wr_en,
  output logic [AW-1:0]          wr_addr,
  output logic [63:0]            wr_data
);

  logic        run_r, run_nxt;
  logic        started_r, started_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [7:0]  rs_r, rs_nxt;
  logic [7:0]  prev_r, prev_nxt;
  logic        bank_r, bank_nxt;
  logic [1:0]  busy_r, busy_nxt;
  logic [63:0] asm_r, asm_nxt;

  logic          accept;
  logic [8:0]    c1;
  logic [7:0]    w_idx;
  logic          w_bank;
  logic          take0, take1;
  bre_pkg::cmd_t cmd0, cmd1;
  logic [1:0]    busy_set;

  assign accept = in_valid && in_ready;
  assign c1     = {1'b0, cnt_r} + 9'd1;

  // A full literal segment writes its next byte into the other bank, so that
  // bank must be free as well.
  assign in_ready = room2 && !busy_r[bank_r] &&
                    !(started_r && !run_r && (cnt_r == 8'(MAX_LITERAL)) && busy_r[!bank_r]);

  always_comb begin
    run_nxt     = run_r;
    started_nxt = started_r;
    cnt_nxt     = cnt_r;
    rs_nxt      = rs_r;
    prev_nxt    = prev_r;
    bank_nxt    = bank_r;
    wr_en       = 1'b0;
    w_idx       = cnt_r;
    w_bank      = bank_r;
    take0       = 1'b0;
    take1       = 1'b0;
    cmd0        = '0;
    cmd1        = '0;
    if (accept) begin
      prev_nxt = in_data_byte;
      if (!started_r) begin
        wr_en       = 1'b1;
        w_idx       = 8'd0;
        cnt_nxt     = 8'd1;
        rs_nxt      = 8'd0;
        run_nxt     = 1'b0;
        started_nxt = 1'b1;
      end else if (!run_r) begin
        wr_en = 1'b1;
        if (c1 > 9'(MAX_LITERAL)) begin
          take0      = 1'b1;
          cmd0.len   = cnt_r;
          cmd0.bank  = bank_r;
          bank_nxt   = !bank_r;
          w_bank     = !bank_r;
          w_idx      = 8'd0;
          cnt_nxt    = 8'd1;
          rs_nxt     = 8'd0;
        end else if (in_data_byte == prev_r) begin
          if ((c1 - {1'b0, rs_r}) >= 9'(bre_pkg::MIN_RUN)) begin
            if (rs_r != 8'd0) begin
              take0     = 1'b1;
              cmd0.len  = rs_r;
              cmd0.bank = bank_r;
              bank_nxt  = !bank_r;
            end
            cnt_nxt = 8'(c1 - {1'b0, rs_r});
            rs_nxt  = 8'd0;
            run_nxt = 1'b1;
          end else if (rs_r == 8'd0) begin
            run_nxt = 1'b1;
            cnt_nxt = 8'(c1);
          end else begin
            cnt_nxt = 8'(c1);
          end
        end else begin
          rs_nxt  = cnt_r;
          cnt_nxt = 8'(c1);
        end
      end else begin
        if ((in_data_byte != prev_r) || (c1 > 9'(MAX_RUN_LEN))) begin
          take0       = 1'b1;
          cmd0.is_run = 1'b1;
          cmd0.len    = cnt_r;
          cmd0.value  = prev_r;
          wr_en       = 1'b1;
          w_idx       = 8'd0;
          cnt_nxt     = 8'd1;
          rs_nxt      = 8'd0;
          run_nxt     = 1'b0;
        end else begin
          cnt_nxt = 8'(c1);
        end
      end

      if (in_row_last) begin
        take1       = 1'b1;
        cmd1.is_run = run_nxt;
        cmd1.len    = cnt_nxt;
        cmd1.value  = in_data_byte;
        cmd1.bank   = bank_nxt;
        if (!run_nxt) begin
          bank_nxt = !bank_nxt;
        end
        started_nxt = 1'b0;
        run_nxt     = 1'b0;
        cnt_nxt     = 8'd0;
        rs_nxt      = 8'd0;
      end

      if (take1) begin
        cmd1.step_last = 1'b1;
        cmd1.row_done  = 1'b1;
      end else begin
        cmd0.step_last = 1'b1;
      end
    end
  end

  always_comb begin
    push = '0;
    if (take0 && take1) begin
      push.n  = 2'd2;
      push.c0 = cmd0;
      push.c1 = cmd1;
    end else if (take1) begin
      push.n  = 2'd1;
      push.c0 = cmd1;
    end else if (take0) begin
      push.n  = 2'd1;
      push.c0 = cmd0;
    end
  end

  always_comb begin
    busy_set = 2'b00;
    if (take0 && !cmd0.is_run) begin
      busy_set[cmd0.bank] = 1'b1;
    end
    if (take1 && !cmd1.is_run) begin
      busy_set[cmd1.bank] = 1'b1;
    end
    busy_nxt = busy_r;
    if (clr.valid) begin
      busy_nxt[clr.bank] = 1'b0;
    end
    busy_nxt = busy_nxt | busy_set;
  end

  // The word being filled is kept here so that every byte write stores a
  // whole word; a segment always starts at byte zero.
  always_comb begin
    for (int i = 0; i < bre_pkg::CHUNK_BYTES; i++) begin
      if (w_idx[2:0] == 3'(i)) begin
        asm_nxt[8*i +: 8] = in_data_byte;
      end else if (w_idx[2:0] == 3'd0) begin
        asm_nxt[8*i +: 8] = 8'h00;
      end else begin
        asm_nxt[8*i +: 8] = asm_r[8*i +: 8];
      end
    end
  end

  assign wr_data = asm_nxt;
  assign wr_addr = AW'(w_idx[WW+2:3]) + (w_bank ? AW'(WORDS) : AW'(0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r     <= 1'b0;
      started_r <= 1'b0;
      cnt_r     <= 8'd0;
      rs_r      <= 8'd0;
      prev_r    <= 8'd0;
      bank_r    <= 1'b0;
      busy_r    <= 2'b00;
    end else begin
      run_r     <= run_nxt;
      started_r <= started_nxt;
      cnt_r     <= cnt_nxt;
      rs_r      <= rs_nxt;
      prev_r    <= prev_nxt;
      bank_r    <= bank_nxt;
      busy_r    <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      asm_r <= asm_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/bre_back.sv
`default_nettype none
module bre_back #(
  parameter int MAX_LITERAL = 128,
  localparam int WORDS = MAX_LITERAL / 8 + 1,
  localparam int WW = (WORDS > 1) ? $clog2(WORDS) : 1,
  localparam int AW = $clog2(2 * WORDS)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire bre_pkg::cmd_t head,
  input  wire logic          empty,
  output logic               pop,
  output logic               rd_en,
  output logic [AW-1:0]      rd_addr,
  input  wire logic [63:0]   rd_data,
  output bre_pkg::bank_clr_t clr,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [63:0]        out_bytes,
  output logic [3:0]         out_byte_count,
  output logic               out_step_last,
  output logic               out_row_done
);

  bre_pkg::bk_state_t st_r, st_nxt;
  bre_pkg::cmd_t      cmd_r, cmd_nxt;
  logic [8:0]         rem_r, rem_nxt;
  logic [WW-1:0]      word_r, word_nxt;
  logic [7:0]         carry_r, carry_nxt;
  logic               first_r, first_nxt;

  logic        ov_r, ov_nxt;
  logic [63:0] ob_r;
  logic [3:0]  oc_r;
  logic        osl_r, ord_r;

  logic        slot_free;
  logic        ld;
  logic [63:0] ld_bytes;
  logic [3:0]  ld_cnt;
  logic        ld_sl, ld_rd;
  logic [WW-1:0] rd_word;
  logic        rd_bank;
  logic        chunk_last;
  logic [63:0] raw;
  logic [7:0]  lit_hdr, run_hdr;

  assign slot_free  = !ov_r || out_ready;
  assign chunk_last = (rem_r <= 9'(bre_pkg::CHUNK_BYTES));
  assign lit_hdr    = cmd_r.len - 8'd1;
  assign run_hdr    = 8'(9'd257 - {1'b0, head.len});
  // Chunk k carries the last byte of word k-1 and the first seven of word k.
  assign raw        = {rd_data[55:0], (first_r ? lit_hdr : carry_r)};

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      bre_pkg::BK_IDLE: begin
        if (!empty && !head.is_run) begin
          st_nxt = bre_pkg::BK_LIT;
        end
      end
      bre_pkg::BK_LIT: begin
        if (slot_free && chunk_last) begin
          st_nxt = bre_pkg::BK_IDLE;
        end
      end
      default: st_nxt = bre_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    rd_en     = 1'b0;
    rd_word   = '0;
    rd_bank   = head.bank;
    ld        = 1'b0;
    ld_bytes  = '0;
    ld_cnt    = 4'd0;
    ld_sl     = 1'b0;
    ld_rd     = 1'b0;
    clr       = '0;
    cmd_nxt   = cmd_r;
    rem_nxt   = rem_r;
    word_nxt  = word_r;
    carry_nxt = carry_r;
    first_nxt = first_r;
    unique case (st_r)
      bre_pkg::BK_IDLE: begin
        if (!empty) begin
          if (head.is_run) begin
            if (slot_free) begin
              pop      = 1'b1;
              ld       = 1'b1;
              ld_bytes = {48'h0, head.value, run_hdr};
              ld_cnt   = 4'd2;
              ld_sl    = head.step_last;
              ld_rd    = head.row_done;
            end
          end else begin
            pop       = 1'b1;
            rd_en     = 1'b1;
            rd_word   = '0;
            rd_bank   = head.bank;
            cmd_nxt   = head;
            rem_nxt   = {1'b0, head.len} + 9'd1;
            word_nxt  = '0;
            first_nxt = 1'b1;
          end
        end
      end
      bre_pkg::BK_LIT: begin
        rd_bank = cmd_r.bank;
        if (slot_free) begin
          ld     = 1'b1;
          ld_cnt = chunk_last ? rem_r[3:0] : 4'(bre_pkg::CHUNK_BYTES);
          for (int i = 0; i < bre_pkg::CHUNK_BYTES; i++) begin
            ld_bytes[8*i +: 8] = (4'(i) < ld_cnt) ? raw[8*i +: 8] : 8'h00;
          end
          if (chunk_last) begin
            ld_sl     = cmd_r.step_last;
            ld_rd     = cmd_r.row_done;
            clr.valid = 1'b1;
            clr.bank  = cmd_r.bank;
          end else begin
            rd_en     = 1'b1;
            rd_word   = word_r + WW'(1);
            word_nxt  = word_r + WW'(1);
            rem_nxt   = rem_r - 9'(bre_pkg::CHUNK_BYTES);
            first_nxt = 1'b0;
            carry_nxt = rd_data[63:56];
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign rd_addr = AW'(rd_word) + (rd_bank ? AW'(WORDS) : AW'(0));
  assign ov_nxt  = ld ? 1'b1 : (out_ready ? 1'b0 : ov_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= bre_pkg::BK_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    rem_r   <= rem_nxt;
    word_r  <= word_nxt;
    carry_r <= carry_nxt;
    first_r <= first_nxt;
    if (ld) begin
      ob_r  <= ld_bytes;
      oc_r  <= ld_cnt;
      osl_r <= ld_sl;
      ord_r <= ld_rd;
    end
  end

  assign out_valid      = ov_r;
  assign out_bytes      = ob_r;
  assign out_byte_count = oc_r;
  assign out_step_last  = osl_r;
  assign out_row_done   = ord_r;

endmodule
`default_nettype wire

// File: rtl/byterun1_row_encoder_unit.sv
// ByteRun1 (PackBits) row encoder.
// Input channel: one row byte per transfer on in_valid/in_ready, with
// in_row_last set on the final byte of the row, which flushes the pending
// packet. Output channel: results of up to eight stream bytes (first byte in
// bits 7..0, unused bytes zero) on out_valid/out_ready; out_step_last marks
// the last result caused by an input byte and out_row_done the row's last.
// The front end takes one byte per cycle and queues up to two packets per
// byte in a four-entry queue; literal bytes go to one of two RAM banks.
// The back end sends a run packet as one result and a literal packet of n
// bytes as ceil((n+1)/8) results, one result per cycle after a RAM read.
// A run result is registered in the queue and the result register; a literal
// waits on a RAM read too. Input stalls when the queue lacks room for two
// packets or when the bank it must write is still being read out.
// Reset is synchronous; it empties the queue, drops any pending result and
// starts a new row. No clearing pass is needed. A stalled receiver holds the
// result register, then the back end, queue and finally the input.
`default_nettype none
module byterun1_row_encoder_unit #(
  parameter int MAX_LITERAL = 128,
  parameter int MAX_RUN_LEN = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_row_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_bytes,
  output logic [3:0]       out_byte_count,
  output logic             out_step_last,
  output logic             out_row_done
);

  localparam int WORDS = MAX_LITERAL / 8 + 1;
  localparam int AW = $clog2(2 * WORDS);

  bre_pkg::push_t     push;
  bre_pkg::cmd_t      head;
  bre_pkg::bank_clr_t clr;
  logic               empty, room2, pop;
  logic               wr_en, rd_en;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [63:0]        wr_data, rd_data;

  bre_front #(
    .MAX_LITERAL (MAX_LITERAL),
    .MAX_RUN_LEN (MAX_RUN_LEN)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_row_last  (in_row_last),
    .room2        (room2),
    .push         (push),
    .clr          (clr),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  bre_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .empty (empty),
    .room2 (room2)
  );

  bre_ram #(
    .WIDTH (64),
    .DEPTH (2 * WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  bre_back #(
    .MAX_LITERAL (MAX_LITERAL)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .empty          (empty),
    .pop            (pop),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .clr            (clr),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_bytes      (out_bytes),
    .out_byte_count (out_byte_count),
    .out_step_last  (out_step_last),
    .out_row_done   (out_row_done)
  );

endmodule
`default_nettype wire

// File: verif/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LIT = 128;
  localparam int MAX_RUN = 128;
  localparam int RANDOM_BYTES = 30;
  localparam int CALM_AFTER = 20;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  count;
    logic        step_last;
    logic        row_done;
  } chunk_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_row_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_bytes;
  logic [3:0]  out_byte_count;
  logic        out_step_last;
  logic        out_row_done;

  byterun1_row_encoder_unit #(
    .MAX_LITERAL(MAX_LIT),
    .MAX_RUN_LEN(MAX_RUN)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data_byte(in_data_byte),
    .in_row_last(in_row_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_bytes(out_bytes),
    .out_byte_count(out_byte_count),
    .out_step_last(out_step_last),
    .out_row_done(out_row_done)
  );

  // Encoder state as seen by the predictor.
  logic       run_mode = 1'b0;
  logic [7:0] lit_buf [0:MAX_LIT];
  int         seg_len = 0;
  int         run_from = 0;
  logic [7:0] prev_byte = 8'h00;
  logic       row_open = 1'b0;
  logic [7:0] pkt_buf [0:MAX_LIT+1];

  chunk_t stream_q[$];
  chunk_t step_chunks[$];

  int  errors = 0;
  int  rows_sent = 0;
  int  bytes_sent = 0;
  int  chunks_seen = 0;
  int  quiet_cycles = 0;
  int  stall_left = 0;
  bit  calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Cuts the packet in pkt_buf into transfers of up to eight bytes.
  function automatic void push_chunks(int len);
    int off;
    int cnt;
    chunk_t c;
    for (off = 0; off < len; off += bre_pkg::CHUNK_BYTES) begin
      cnt = (len - off > bre_pkg::CHUNK_BYTES) ? bre_pkg::CHUNK_BYTES : len - off;
      c = '0;
      for (int i = 0; i < cnt; i++) c.bytes[8*i +: 8] = pkt_buf[off + i];
      c.count = 4'(cnt);
      step_chunks.push_back(c);
    end
  endfunction

  function automatic void literal_packet(int len);
    if (len == 0) return;
    if (len > MAX_LIT) len = MAX_LIT;
    pkt_buf[0] = 8'(len - 1);
    for (int i = 0; i < len; i++) pkt_buf[i + 1] = lit_buf[i];
    push_chunks(len + 1);
  endfunction

  function automatic void run_packet(int len, logic [7:0] value);
    pkt_buf[0] = 8'(257 - len);
    pkt_buf[1] = value;
    push_chunks(2);
  endfunction

  function automatic void encode_byte(logic [7:0] b, logic last);
    chunk_t c;
    step_chunks.delete();
    if (!row_open) begin
      lit_buf[0] = b;
      seg_len = 1;
      run_from = 0;
      run_mode = 1'b0;
      row_open = 1'b1;
    end else if (!run_mode) begin
      if (seg_len <= MAX_LIT) lit_buf[seg_len] = b;
      seg_len++;
      if (seg_len > MAX_LIT) begin
        // A full buffer leaves as is; the new byte starts over and is not
        // compared with the one before it.
        literal_packet(seg_len - 1);
        lit_buf[0] = b;
        seg_len = 1;
        run_from = 0;
      end else if (b == prev_byte) begin
        if (seg_len - run_from >= bre_pkg::MIN_RUN) begin
          if (run_from > 0) literal_packet(run_from);
          seg_len -= run_from;
          run_from = 0;
          run_mode = 1'b1;
        end else if (run_from == 0) begin
          run_mode = 1'b1;
        end
      end else begin
        run_from = seg_len - 1;
      end
    end else begin
      seg_len++;
      if (b != prev_byte || seg_len > MAX_RUN) begin
        run_packet(seg_len - 1, prev_byte);
        lit_buf[0] = b;
        seg_len = 1;
        run_from = 0;
        run_mode = 1'b0;
      end
    end
    prev_byte = b;

    if (last) begin
      if (run_mode) run_packet(seg_len, prev_byte);
      else literal_packet(seg_len);
      row_open = 1'b0;
      run_mode = 1'b0;
      seg_len = 0;
      run_from = 0;
    end

    if (step_chunks.size() > 0) begin
      c = step_chunks.pop_back();
      c.step_last = 1'b1;
      c.row_done = last;
      step_chunks.push_back(c);
    end
    foreach (step_chunks[i]) stream_q.push_back(step_chunks[i]);
  endfunction

  function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      errors++;
    end
  endfunction

  // Checks each result transfer, predicts on each input transfer, and
  // watches for the handshakes going quiet.
  always @(posedge clk) begin
    chunk_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        chunks_seen++;
        if (stream_q.size() == 0) begin
          $display("%0t: unexpected result, expected nothing, got bytes %h count %0d",
                   $time, out_bytes, out_byte_count);
          errors++;
        end else begin
          want = stream_q.pop_front();
          check_field("out_bytes", want.bytes, out_bytes);
          check_field("out_byte_count", 64'(want.count), 64'(out_byte_count));
          check_field("out_step_last", 64'(want.step_last), 64'(out_step_last));
          check_field("out_row_done", 64'(want.row_done), 64'(out_row_done));
        end
      end
      if (in_valid && in_ready) encode_byte(in_data_byte, in_row_last);
      if ((out_valid && out_ready) || (in_valid && in_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                   $time, quiet_cycles, stream_q.size());
          $display("testbench: done, errors");
          $finish;
        end
      end
    end
  end

  // Receiver back-pressure in random bursts.
  always @(negedge clk) begin
    if (calm || !rst_n) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic sender_gap();
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 14);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_row(input byte_q_t row);
    for (int i = 0; i < row.size(); i++) begin
      sender_gap();
      @(negedge clk);
      in_valid <= 1'b1;
      in_data_byte <= row[i];
      in_row_last <= (i == row.size() - 1);
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      bytes_sent++;
    end
    rows_sent++;
  endtask

  task automatic test_single_byte_rows();
    send_row({8'h00});
    send_row({8'hFF});
  endtask

  task automatic test_run_detection();
    // Two equal bytes opening a segment, three equal bytes after a literal,
    // a pair inside a literal, a run broken by a new byte, a run at row end.
    send_row({8'h41, 8'h41});
    send_row({8'h01, 8'h02, 8'h03, 8'h03, 8'h03, 8'h04});
    send_row({8'h05, 8'h06, 8'h06, 8'h07});
    send_row({8'h7F, 8'h7F, 8'h7F, 8'h80});
    send_row({8'hAA, 8'hAA, 8'hAA, 8'hAA});
  endtask

  task automatic test_buffer_limits();
    byte_q_t row;
    logic [7:0] b;
    // Full literal buffer: the 129th byte repeats the 128th but must not
    // start a run, and it also ends the row.
    for (int i = 0; i < MAX_LIT; i++) begin
      b = 8'($urandom);
      if (row.size() > 0 && b == row[$]) b = ~b;
      row.push_back(b);
    end
    row.push_back(row[$]);
    send_row(row);
    // Run cap: one run too long splits into a full run and a short one.
    row.delete();
    b = 8'($urandom);
    repeat (MAX_RUN + 2) row.push_back(b);
    send_row(row);
  endtask

  task automatic test_random_rows();
    byte_q_t row;
    logic [7:0] v;
    int len;
    int rep;
    int start;
    bit paused;
    start = bytes_sent;
    paused = 1'b0;
    // The last rows always go out with no idling on either side.
    while (bytes_sent - start < RANDOM_BYTES || !calm) begin
      len = ($urandom_range(0, 6) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
      row.delete();
      while (row.size() < len) begin
        v = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 3));
        rep = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(1, 6);
        repeat (rep) if (row.size() < len) row.push_back(v);
      end
      if (bytes_sent - start >= CALM_AFTER) calm = 1'b1;
      send_row(row);
      if (!paused && bytes_sent - start >= RANDOM_BYTES / 2) begin
        // Let the encoder drain completely before the next row.
        paused = 1'b1;
        @(negedge clk);
        in_valid <= 1'b0;
        while (stream_q.size() != 0) @(posedge clk);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_single_byte_rows();
    test_run_detection();
    test_buffer_limits();
    test_random_rows();

    @(negedge clk);
    in_valid <= 1'b0;
    while (stream_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Encoded %0d rows, %0d bytes in all, checked %0d result transfers;",
             rows_sent, bytes_sent, chunks_seen);
    $display("rows covered single bytes, short runs, a full literal buffer and a capped run.");
    if (errors == 0 && stream_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: byterun1_row_encoder_unit.f
rtl/bre_pkg.sv
rtl/bre_ram.sv
rtl/bre_cmd_fifo.sv
rtl/bre_front.sv
rtl/bre_back.sv
rtl/byterun1_row_encoder_unit.sv
verif/testbench.sv
